// ===== src/msl_pkg.sv =====
package msl_pkg;

	// Field widths fixed by the item format
	localparam int REF_W = 31;
	localparam int ROW_W = 6;

	// Default sizes of the lookup storage
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ROW_COUNT_DEF   = 64;

	typedef logic [REF_W-1:0] ref_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		CFG_MULTIMAT   = 1'b0,
		CFG_REF_OFFSET = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TAKEN   = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// Attribute codes held in the low two bits of a table entry
	localparam logic [1:0] ATTR_KEEP   = 2'd0;
	localparam logic [1:0] ATTR_PARENT = 2'd1;
	localparam logic [1:0] ATTR_OUTER  = 2'd2;
	localparam logic [1:0] ATTR_INNER  = 2'd3;

	// Interior plus exterior attribute marks a pair on the level set
	localparam logic [2:0] LEVEL_SET_SUM = 3'd5;

	typedef struct packed {
		op_t              operation;
		logic [ROW_W-1:0] row_index;
		ref_t             main_ref;
		logic             split_flag;
		ref_t             inner_ref;
		ref_t             outer_ref;
		ref_t             other_ref;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic       found;
		ref_t       start_ref;
		logic       can_split;
		ref_t       split_inner_ref;
		ref_t       split_outer_ref;
		logic       not_split;
		logic       on_level_set;
		logic [1:0] attribute;
	} result_t;

endpackage

// ===== src/material_split_lookup_table.sv =====
// Material split lookup table. A load beat stores one material row and enters its parent
// and, when split, its interior and exterior child references in a direct-mapped inverse
// table keyed by reference minus ref_offset; a query beat looks up a reference pair and
// returns the parent, split labels and level-set flag. Each of the two tables is a
// single-port synchronous memory. A query in default mode or on a key out of range, and a
// load with a range error, skip the table; other items read it in turn and a load that is
// not refused then writes its entries. No new item is taken until the last is through.
// After reset the inverse table is swept to zero, one entry a cycle; no item is accepted
// meanwhile, but configuration writes are. A finished result waits in an output register
// while the next item is taken.
module material_split_lookup_table #(
	parameter int TABLE_DEPTH = msl_pkg::TABLE_DEPTH_DEF,
	parameter int ROW_COUNT   = msl_pkg::ROW_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msl_pkg::item_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output msl_pkg::result_t    out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  msl_pkg::cfg_index_t cfg_index,
	input  msl_pkg::ref_t       cfg_data
);
	import msl_pkg::*;

	localparam int KW  = $clog2(TABLE_DEPTH);
	localparam int RNW = $clog2(ROW_COUNT + 1);
	localparam int EW  = RNW + 2;
	localparam int RW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int RXW = (RW > ROW_W) ? RW : ROW_W;

	typedef enum logic [11:0] {
		S_CLR  = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_RD0  = 12'b000000000100,
		S_RD1  = 12'b000000001000,
		S_RD2  = 12'b000000010000,
		S_EVAL = 12'b000000100000,
		S_WR0  = 12'b000001000000,
		S_WR1  = 12'b000010000000,
		S_WR2  = 12'b000100000000,
		S_OUT  = 12'b001000000000
	} state_t;

	typedef struct packed {
		ref_t parent;
		logic split;
		ref_t inner;
		ref_t outer;
	} row_word_t;

	state_t          state_q;
	logic            mm_q;
	ref_t            offset_q;
	logic [KW-1:0]   clr_q;
	logic            out_valid_q;

	item_t           item_q;
	logic [KW-1:0]   kp_q, k1_q, ko_q;
	logic            k1_ok_q;
	status_t         status_q;
	logic [EW-1:0]   e0_q, e1_q;
	result_t         out_q;

	logic [REF_W:0]  dp, d1, dq;
	logic            okp, ok1, oko, row_ok;
	ref_t            src1;

	logic [EW-1:0]   tbl_mem [TABLE_DEPTH];
	logic [KW-1:0]   tbl_addr;
	logic            tbl_we;
	logic [EW-1:0]   tbl_wdata;
	logic [EW-1:0]   tbl_rd_q;

	row_word_t       row_mem [ROW_COUNT];
	logic [RW-1:0]   row_addr;
	logic            row_we, row_re;
	row_word_t       row_wdata;
	row_word_t       row_rd_q;

	logic [RNW-1:0]  base;
	logic [RXW-1:0]  row_ext;
	logic [RNW-1:0]  qrow_full;
	logic            qrow_ok;
	logic            collide;
	logic [1:0]      a0, a1;
	logic            out_load;
	result_t         res;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// Form table keys and range checks for the incoming beat
	always_comb begin
		src1   = (in_data.operation == OP_QUERY) ? in_data.other_ref : in_data.inner_ref;
		dp     = {1'b0, in_data.main_ref} - {1'b0, offset_q};
		d1     = {1'b0, src1} - {1'b0, offset_q};
		dq     = {1'b0, in_data.outer_ref} - {1'b0, offset_q};
		okp    = !dp[REF_W] && (dp[REF_W-1:0] < REF_W'(TABLE_DEPTH));
		ok1    = !d1[REF_W] && (d1[REF_W-1:0] < REF_W'(TABLE_DEPTH));
		oko    = !dq[REF_W] && (dq[REF_W-1:0] < REF_W'(TABLE_DEPTH));
		row_ok = 32'(in_data.row_index) < 32'(ROW_COUNT);
	end

	// Row arithmetic for loads and queries
	always_comb begin
		base      = RNW'(item_q.row_index) + RNW'(1);
		row_ext   = RXW'(item_q.row_index);
		qrow_full = e0_q[EW-1:2] - RNW'(1);
		qrow_ok   = 32'(qrow_full) < 32'(ROW_COUNT);
		a0        = e0_q[1:0];
		a1        = k1_ok_q ? e1_q[1:0] : ATTR_KEEP;
		collide   = (e0_q != '0) ||
			(item_q.split_flag && (((k1_q != kp_q) && (e1_q != '0)) || (ko_q == k1_q) ||
			((ko_q != kp_q) && (tbl_rd_q != '0))));
	end

	// Drive the inverse table port from the sequencer state
	always_comb begin
		tbl_addr  = kp_q;
		tbl_we    = 1'b0;
		tbl_wdata = '0;
		case (state_q)
			S_CLR: begin
				tbl_addr = clr_q;
				tbl_we   = 1'b1;
			end
			S_RD0: tbl_addr = kp_q;
			S_RD1: tbl_addr = k1_q;
			S_RD2: tbl_addr = ko_q;
			S_WR0: begin
				tbl_addr  = kp_q;
				tbl_we    = 1'b1;
				tbl_wdata = {base, item_q.split_flag ? ATTR_PARENT : ATTR_KEEP};
			end
			S_WR1: begin
				tbl_addr  = k1_q;
				tbl_we    = 1'b1;
				tbl_wdata = {base, ATTR_INNER};
			end
			S_WR2: begin
				tbl_addr  = ko_q;
				tbl_we    = 1'b1;
				tbl_wdata = {base, ATTR_OUTER};
			end
			default: tbl_addr = kp_q;
		endcase
	end

	// Drive the row memory port
	always_comb begin
		row_we          = (state_q == S_WR0);
		row_re          = (state_q == S_EVAL) && (item_q.operation == OP_QUERY) && qrow_ok;
		row_addr        = row_we ? row_ext[RW-1:0] : qrow_full[RW-1:0];
		row_wdata.parent = item_q.main_ref;
		row_wdata.split  = item_q.split_flag;
		row_wdata.inner  = item_q.split_flag ? item_q.inner_ref : '0;
		row_wdata.outer  = item_q.split_flag ? item_q.outer_ref : '0;
	end

	// Inverse table: one port, read data registered
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_addr] <= tbl_wdata;
		end
		tbl_rd_q <= tbl_mem[tbl_addr];
	end

	// Row table: one port, read data registered and held
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_addr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q <= row_mem[row_addr];
		end
	end

	// Assemble the result beat
	always_comb begin
		res = '0;
		if (item_q.operation == OP_LOAD) begin
			res.status = status_q;
		end else if (!mm_q) begin
			res.found           = 1'b1;
			res.can_split       = 1'b1;
			res.split_inner_ref = REF_W'(ATTR_INNER);
			res.split_outer_ref = REF_W'(ATTR_OUTER);
			res.on_level_set    =
				((item_q.main_ref == REF_W'(ATTR_INNER)) &&
				(item_q.other_ref == REF_W'(ATTR_OUTER))) ||
				((item_q.main_ref == REF_W'(ATTR_OUTER)) &&
				(item_q.other_ref == REF_W'(ATTR_INNER)));
		end else if (status_q != ST_OK) begin
			res.status = status_q;
		end else begin
			res.found           = 1'b1;
			res.start_ref       = row_rd_q.parent;
			res.can_split       = row_rd_q.split;
			res.split_inner_ref = row_rd_q.split ? row_rd_q.inner : '0;
			res.split_outer_ref = row_rd_q.split ? row_rd_q.outer : '0;
			res.not_split       = (a0 != ATTR_KEEP);
			res.on_level_set    = (({1'b0, a0} + {1'b0, a1}) == LEVEL_SET_SUM);
			res.attribute       = a0;
		end
	end

	// Sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			mm_q        <= 1'b0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MULTIMAT:   mm_q     <= cfg_data[0];
					CFG_REF_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + KW'(1);
					if (clr_q == KW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.operation == OP_LOAD) begin
							if (!row_ok || !okp || (in_data.split_flag && (!ok1 || !oko))) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_RD0;
							end
						end else if (!mm_q || !okp) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_EVAL;
				S_EVAL: begin
					if (item_q.operation == OP_LOAD && !collide) begin
						state_q <= S_WR0;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_WR0: state_q <= item_q.split_flag ? S_WR1 : S_OUT;
				S_WR1: state_q <= S_WR2;
				S_WR2: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold item, keys, entries and status for the beat at work
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q  <= in_data;
			kp_q    <= dp[KW-1:0];
			k1_q    <= d1[KW-1:0];
			ko_q    <= dq[KW-1:0];
			k1_ok_q <= ok1;
			if (in_data.operation == OP_LOAD) begin
				if (!row_ok || !okp || (in_data.split_flag && (!ok1 || !oko))) begin
					status_q <= ST_RANGE;
				end else begin
					status_q <= ST_OK;
				end
			end else if (mm_q && !okp) begin
				status_q <= ST_RANGE;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (state_q == S_RD1) begin
			e0_q <= tbl_rd_q;
		end
		if (state_q == S_RD2) begin
			e1_q <= tbl_rd_q;
		end
		if (state_q == S_EVAL) begin
			if (item_q.operation == OP_LOAD) begin
				if (collide) begin
					status_q <= ST_TAKEN;
				end
			end else if (e0_q == '0 || !qrow_ok) begin
				status_q <= ST_MISSING;
			end
		end
		if (out_load) begin
			out_q <= res;
		end
	end

endmodule

// ===== src/msl_checker.sv =====
module msl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input msl_pkg::result_t out_data
);
	import msl_pkg::*;

	// One item at a time: an accepted beat closes the input until it is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again in the cycle after an accept");

	// A stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A failed beat carries status alone
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> !out_data.found && !out_data.can_split &&
		out_data.start_ref == '0 && out_data.attribute == ATTR_KEEP && !out_data.on_level_set)
		else $error("failed beat carries lookup fields");

	// The not-split flag follows the attribute
	a_not_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.not_split == (out_data.attribute != ATTR_KEEP))
		else $error("not_split disagrees with attribute");

	// An unsplit parent gives no child labels
	a_unsplit_labels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found && !out_data.can_split |->
		out_data.split_inner_ref == '0 && out_data.split_outer_ref == '0)
		else $error("child labels on an unsplit parent");

endmodule

bind material_split_lookup_table msl_checker u_msl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
